[hw/rtl/sas_pkg.sv]
// Shared sizes, configuration register codes, command/status types and
// score saturation for the sequence alignment score block.
// No dependencies.
package sas_pkg;

  // Store sizes and field widths
  localparam int REF_DEPTH   = 256;
  localparam int ADDR_W      = $clog2(REF_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int QUERY_DEPTH = 1024;
  localparam int ROW_W       = $clog2(QUERY_DEPTH) + 1;
  localparam int SCORE_W     = 20;
  localparam int EXT_W       = SCORE_W + 2;
  localparam int SYM_W       = 8;
  localparam int PARAM_W     = 8;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_SCORE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_SCORE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT        = 3'd4;

  // Input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Score limits
  localparam logic signed [SCORE_W-1:0] SMAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SMIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] EXT_SMAX = {3'b000, {(SCORE_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] EXT_SMIN = {3'b111, {(SCORE_W-1){1'b0}}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // reference symbol transfer
    logic take;   // query symbol transfer, latch symbol and last
    logic start;  // set up a row
    logic skip;   // query too long, row not computed
    logic step;   // compute one column
    logic emit;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic row_full;
    logic ref_empty;
    logic col_last;
    logic last_q;
    logic out_free;
  } status_t;

  // Clamp an extended score into the signed score range
  function automatic logic signed [SCORE_W-1:0] sat_score(
      input logic signed [EXT_W-1:0] v);
    logic signed [SCORE_W-1:0] r;
    if (v > EXT_SMAX) r = SMAX;
    else if (v < EXT_SMIN) r = SMIN;
    else r = v[SCORE_W-1:0];
    return r;
  endfunction

endpackage

[hw/rtl/sas_ctrl.sv]
// Sequencing state machine for the sequence alignment score block.
// Depends on sas_pkg (cmd_t, status_t, OP_* codes).
module sas_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  sas_pkg::status_t sts,
  output sas_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_COMP  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == sas_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.take   = 1'b1;
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        if (sts.row_full) begin
          cmd.skip   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.start  = 1'b1;
          state_next = sts.ref_empty ? ST_DONE : ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.step = 1'b1;
        if (sts.col_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.last_q) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

[hw/rtl/sas_dp.sv]
// Datapath: configuration registers, reference and previous-row memories,
// the per-column cell update, best-cell tracking and the result register.
// Depends on sas_pkg.
module sas_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sas_pkg::PARAM_W-1:0]         cfg_data,
  input  logic [sas_pkg::SYM_W-1:0]           symbol,
  input  logic                                last,
  input  sas_pkg::cmd_t                       cmd,
  output sas_pkg::status_t                    sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sas_pkg::SCORE_W-1:0]  score,
  output logic [sas_pkg::ROW_W-1:0]           best_row,
  output logic [sas_pkg::LEN_W-1:0]           best_col,
  output logic                                overflow
);

  localparam int SW = sas_pkg::SCORE_W;
  localparam int XW = sas_pkg::EXT_W;
  localparam int PW = sas_pkg::PARAM_W;

  // Configuration registers
  logic          global_mode;
  logic [PW-1:0] match_score;
  logic [PW-1:0] mismatch_score;
  logic [PW-1:0] gap_open;
  logic [PW-1:0] gap_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_mode    <= 1'b0;
      match_score    <= 8'sd2;
      mismatch_score <= 8'hFF;
      gap_open       <= 8'd2;
      gap_ext        <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        sas_pkg::REG_GLOBAL_MODE:    global_mode    <= cfg_data[0];
        sas_pkg::REG_MATCH_SCORE:    match_score    <= cfg_data;
        sas_pkg::REG_MISMATCH_SCORE: mismatch_score <= cfg_data;
        sas_pkg::REG_GAP_OPEN:       gap_open       <= cfg_data;
        sas_pkg::REG_GAP_EXT:        gap_ext        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence state
  logic [sas_pkg::LEN_W-1:0]   ref_len;
  logic                        ref_closed;
  logic                        ref_ovf;
  logic [sas_pkg::ROW_W-1:0]   row_index;
  logic                        query_ovf;
  logic [sas_pkg::SYM_W-1:0]   sym_q;
  logic                        last_q;

  // Row walk registers
  logic [sas_pkg::LEN_W-1:0]   col;
  logic signed [SW-1:0]        diag;
  logic signed [SW-1:0]        left;
  logic signed [SW-1:0]        col0;
  logic signed [SW-1:0]        border;
  logic signed [SW-1:0]        best_score;
  logic [sas_pkg::ROW_W-1:0]   best_r;
  logic [sas_pkg::LEN_W-1:0]   best_c;

  // Memories
  logic [sas_pkg::SYM_W-1:0] ref_mem  [sas_pkg::REF_DEPTH];
  logic [SW-1:0]             prev_mem [sas_pkg::REF_DEPTH];
  logic [sas_pkg::SYM_W-1:0] ref_q;
  logic [SW-1:0]             prev_q;
  logic [sas_pkg::ADDR_W-1:0] rd_addr;
  logic [sas_pkg::ADDR_W-1:0] wr_addr;

  // Load-side length after a possible restart of the reference
  logic [sas_pkg::LEN_W-1:0] len_eff;
  assign len_eff = ref_closed ? '0 : ref_len;

  assign rd_addr = cmd.start ? '0 : col[sas_pkg::ADDR_W-1:0];
  assign wr_addr = col[sas_pkg::ADDR_W-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load && len_eff < sas_pkg::LEN_W'(sas_pkg::REF_DEPTH))
      ref_mem[len_eff[sas_pkg::ADDR_W-1:0]] <= symbol;
    ref_q <= ref_mem[rd_addr];
  end

  // Row setup values
  logic                 first_row;
  logic signed [SW-1:0] col0_old;
  logic signed [SW-1:0] col0_new;
  logic signed [XW-1:0] gap_open_x;

  assign first_row  = (row_index == '0);
  assign col0_old   = first_row ? '0 : col0;
  assign gap_open_x = {{(XW-PW){1'b0}}, gap_open};
  assign col0_new   = global_mode
                      ? sas_pkg::sat_score({{2{col0_old[SW-1]}}, col0_old} - gap_open_x)
                      : '0;

  // Cell update
  logic signed [SW-1:0] border_j;
  logic signed [SW-1:0] up;
  logic signed [XW-1:0] pen_x;
  logic [PW-1:0]        sub;
  logic signed [XW-1:0] cand_diag;
  logic signed [XW-1:0] cand_up;
  logic signed [XW-1:0] cand_left;
  logic signed [XW-1:0] v_max;
  logic signed [SW-1:0] v_sat;

  always_comb begin
    border_j  = global_mode
                ? sas_pkg::sat_score({{2{border[SW-1]}}, border} - gap_open_x)
                : '0;
    up        = first_row ? border_j : prev_q;
    pen_x     = {{(XW-PW){1'b0}}, gap_open} + {{(XW-PW){1'b0}}, gap_ext};
    sub       = (sym_q == ref_q) ? match_score : mismatch_score;
    cand_diag = {{2{diag[SW-1]}}, diag} + {{(XW-PW){sub[PW-1]}}, sub};
    cand_up   = {{2{up[SW-1]}}, up} - pen_x;
    cand_left = {{2{left[SW-1]}}, left} - pen_x;
    v_max     = cand_diag;
    if (!first_row && cand_up > v_max) v_max = cand_up;
    if (col != sas_pkg::LEN_W'(1) && cand_left > v_max) v_max = cand_left;
    v_sat = sas_pkg::sat_score(v_max);
    if (!global_mode && v_sat < 0) v_sat = '0;
  end

  // Previous-row memory: column j lives at address j-1
  always_ff @(posedge clk) begin
    if (cmd.step) prev_mem[wr_addr] <= v_sat;
    prev_q <= prev_mem[rd_addr];
  end

  // Sequence and row state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len    <= '0;
      ref_closed <= 1'b0;
      ref_ovf    <= 1'b0;
      row_index  <= '0;
      query_ovf  <= 1'b0;
      best_score <= sas_pkg::SMIN;
      best_r     <= '0;
      best_c     <= '0;
    end else begin
      if (cmd.load) begin
        ref_closed <= last;
        if (len_eff < sas_pkg::LEN_W'(sas_pkg::REF_DEPTH)) begin
          ref_len <= len_eff + 1'b1;
          if (ref_closed) ref_ovf <= 1'b0;
        end else begin
          ref_len <= len_eff;
          ref_ovf <= 1'b1;
        end
        row_index <= '0;
      end
      if (cmd.skip) query_ovf <= 1'b1;
      if (cmd.start) begin
        if (first_row) begin
          query_ovf  <= 1'b0;
          best_score <= global_mode ? sas_pkg::SMIN : '0;
          best_r     <= '0;
          best_c     <= '0;
        end
        if (ref_len == '0) row_index <= row_index + 1'b1;
      end
      if (cmd.step) begin
        if (!global_mode && v_sat > best_score) begin
          best_score <= v_sat;
          best_r     <= row_index + 1'b1;
          best_c     <= col;
        end
        if (col == ref_len) row_index <= row_index + 1'b1;
      end
      if (cmd.emit) row_index <= '0;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sym_q  <= symbol;
      last_q <= last;
    end
    if (cmd.start) begin
      diag   <= col0_old;
      left   <= col0_new;
      col0   <= col0_new;
      border <= '0;
      col    <= sas_pkg::LEN_W'(1);
    end
    if (cmd.step) begin
      diag   <= up;
      left   <= v_sat;
      border <= border_j;
      col    <= col + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      overflow <= query_ovf | ref_ovf;
      if (global_mode) begin
        score    <= left;
        best_row <= row_index;
        best_col <= ref_len;
      end else begin
        score    <= best_score;
        best_row <= best_r;
        best_col <= best_c;
      end
    end
  end

  // Status
  assign sts.row_full  = (row_index >= sas_pkg::ROW_W'(sas_pkg::QUERY_DEPTH));
  assign sts.ref_empty = (ref_len == '0);
  assign sts.col_last  = (col == ref_len);
  assign sts.last_q    = last_q;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

[hw/rtl/sequence_alignment_score_top.sv]
// Sequence alignment score block: top level joining the controller and
// the datapath. Depends on sas_pkg, sas_ctrl and sas_dp.
//
// Usage: a reference is loaded over the input channel with op=0, one
// symbol per transfer, last=1 on its final symbol (up to 256 symbols are
// kept; more set the overflow flag). Query symbols follow with op=1; each
// computes one row of the score matrix, and the query symbol with last=1
// produces one result on the output channel (score, best_row, best_col,
// overflow). The configuration channel writes global_mode, match_score,
// mismatch_score, gap_open and gap_ext at indexes 0 to 4 and is always ready.
// Sequencing: a reference symbol is taken without leaving the idle state. A
// query symbol passes through transfer, row setup, one reference column per
// cycle through the previous-row memory, and wrap-up.
// The result register holds a finished result while the next item is taken;
// if the receiver still stalls when the next result is ready, the block
// waits in wrap-up until the result register frees.
// Reset clears the controller state, configuration registers, lengths and flags; no clearing pass is run.
module sequence_alignment_score_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sas_pkg::PARAM_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [sas_pkg::SYM_W-1:0]           symbol,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sas_pkg::SCORE_W-1:0]  score,
  output logic [sas_pkg::ROW_W-1:0]           best_row,
  output logic [sas_pkg::LEN_W-1:0]           best_col,
  output logic                                overflow
);

  sas_pkg::cmd_t    cmd;
  sas_pkg::status_t sts;

  // Configuration writes are always accepted and land directly in the registers
  assign cfg_ready = 1'b1;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  sas_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .symbol    (symbol),
    .last      (last),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score),
    .best_row  (best_row),
    .best_col  (best_col),
    .overflow  (overflow)
  );

endmodule

[sim/tb_sequence_alignment_score_top.sv]
// Testbench for sequence_alignment_score_top: directed and random reference/query
// traffic, checked result by result against a cycle-free alignment score predictor.
// Depends on sas_pkg and the sequence_alignment_score_top RTL.
module tb_sequence_alignment_score_top;
  import sas_pkg::*;

  localparam int SCORE_HI       = (1 << (SCORE_W - 1)) - 1;
  localparam int SCORE_LO       = -SCORE_HI - 1;
  localparam int DRAIN_CYCLES   = 300;    // one full-width row plus margin
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int HOLD_CYCLES    = 1500;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   row;
    logic [LEN_W-1:0]   col;
    logic               ovf;
  } align_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PARAM_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [SYM_W-1:0]     symbol;
  logic                 last;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SCORE_W-1:0] score;
  logic [ROW_W-1:0]     best_row;
  logic [LEN_W-1:0]     best_col;
  logic                 overflow;

  // Predictor state
  logic [SYM_W-1:0] ref_sym [REF_DEPTH];
  int  ref_len;
  int  prev_row [REF_DEPTH+1];
  int  row_idx;
  int  best_val;
  int  best_r;
  int  best_c;
  bit  query_ovf;
  bit  ref_closed;
  bit  ref_ovf;
  bit  cfg_global;
  int  cfg_match;
  int  cfg_mismatch;
  int  cfg_gap_open;
  int  cfg_gap_ext;

  align_result_t pending_scores[$];
  align_result_t got_exp;

  int  n_fail;
  int  n_queries;
  int  quiet_cycles;
  bit  idle_en;
  int  hold_len;

  sequence_alignment_score_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .symbol    (symbol),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score),
    .best_row  (best_row),
    .best_col  (best_col),
    .overflow  (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Alignment score predictor
  // ---------------------------------------------------------------------
  function automatic int clamp_score(int v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  function automatic void reset_predictor();
    cfg_global   = 1'b0;
    cfg_match    = 2;
    cfg_mismatch = -1;
    cfg_gap_open = 2;
    cfg_gap_ext  = 1;
    foreach (ref_sym[k]) ref_sym[k] = '0;
    foreach (prev_row[k]) prev_row[k] = 0;
    ref_len    = 0;
    row_idx    = 0;
    best_val   = SCORE_LO;
    best_r     = 0;
    best_c     = 0;
    query_ovf  = 1'b0;
    ref_closed = 1'b0;
    ref_ovf    = 1'b0;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [PARAM_W-1:0] data);
    case (idx)
      REG_GLOBAL_MODE:    cfg_global   = data[0];
      REG_MATCH_SCORE:    cfg_match    = int'($signed(data));
      REG_MISMATCH_SCORE: cfg_mismatch = int'($signed(data));
      REG_GAP_OPEN:       cfg_gap_open = int'(data);
      REG_GAP_EXT:        cfg_gap_ext  = int'(data);
      default: ;
    endcase
  endfunction

  // Row zero borders; the mode at the first query symbol decides them
  function automatic void start_query_rows();
    query_ovf   = 1'b0;
    row_idx     = 0;
    prev_row[0] = 0;
    for (int j = 1; j <= ref_len; j++)
      prev_row[j] = cfg_global ? clamp_score(prev_row[j-1] - cfg_gap_open) : 0;
    best_r   = 0;
    best_c   = 0;
    best_val = cfg_global ? SCORE_LO : 0;
  endfunction

  function automatic void fill_score_row(logic [SYM_W-1:0] s);
    int i;
    int pen;
    int diag;
    int left;
    int up;
    int v;
    i    = row_idx + 1;
    pen  = cfg_gap_open + cfg_gap_ext;
    diag = prev_row[0];
    left = cfg_global ? clamp_score(prev_row[0] - cfg_gap_open) : 0;
    prev_row[0] = left;
    for (int j = 1; j <= ref_len; j++) begin
      up = prev_row[j];
      v  = diag + ((s == ref_sym[j-1]) ? cfg_match : cfg_mismatch);
      if (i >= 2 && up - pen > v) v = up - pen;
      if (j >= 2 && left - pen > v) v = left - pen;
      v = clamp_score(v);
      if (!cfg_global && v < 0) v = 0;
      diag        = up;
      prev_row[j] = v;
      left        = v;
      // first strictly greatest cell in row-major order
      if (!cfg_global && v > best_val) begin
        best_val = v;
        best_r   = i;
        best_c   = j;
      end
    end
    row_idx = i;
  endfunction

  function automatic void predict_alignment(logic o, logic [SYM_W-1:0] s, logic is_last);
    align_result_t r;
    if (o == OP_LOAD) begin
      // a load after a closed reference starts a new one; any query is dropped
      if (ref_closed) begin
        ref_len    = 0;
        ref_ovf    = 1'b0;
        ref_closed = 1'b0;
      end
      if (ref_len < REF_DEPTH) begin
        ref_sym[ref_len] = s;
        ref_len++;
      end else begin
        ref_ovf = 1'b1;
      end
      if (is_last) ref_closed = 1'b1;
      row_idx = 0;
      return;
    end
    if (row_idx == 0) start_query_rows();
    if (row_idx < QUERY_DEPTH) fill_score_row(s);
    else query_ovf = 1'b1;
    if (!is_last) return;
    if (cfg_global) begin
      r.score = SCORE_W'(prev_row[ref_len]);
      r.row   = ROW_W'(row_idx);
      r.col   = LEN_W'(ref_len);
    end else begin
      r.score = SCORE_W'(best_val);
      r.row   = ROW_W'(best_r);
      r.col   = LEN_W'(best_c);
    end
    r.ovf = query_ovf || ref_ovf;
    pending_scores.push_back(r);
    row_idx = 0;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: a transfer is sampled at the falling edge ahead of its edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        $error("result transfer with no expected score pending");
        n_fail++;
      end else begin
        got_exp = pending_scores.pop_front();
        if (score !== got_exp.score) begin
          $error("score mismatch: expected %0d actual %0d",
                 $signed(got_exp.score), score);
          n_fail++;
        end
        if (best_row !== got_exp.row) begin
          $error("best_row mismatch: expected %0d actual %0d", got_exp.row, best_row);
          n_fail++;
        end
        if (best_col !== got_exp.col) begin
          $error("best_col mismatch: expected %0d actual %0d", got_exp.col, best_col);
          n_fail++;
        end
        if (overflow !== got_exp.ovf) begin
          $error("overflow mismatch: expected %0d actual %0d", got_exp.ovf, overflow);
          n_fail++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Drivers (entered and left at a rising edge)
  // ---------------------------------------------------------------------
  task automatic send_item(logic o, logic [SYM_W-1:0] s, logic is_last);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    symbol   <= s;
    last     <= is_last;
    do @(negedge clk); while (!in_ready);
    predict_alignment(o, s, is_last);
    if (o == OP_QUERY) n_queries++;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PARAM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    apply_config(idx, data);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(bit g, int m, int mm, int go, int ge);
    write_reg(REG_GLOBAL_MODE, PARAM_W'(g));
    write_reg(REG_MATCH_SCORE, PARAM_W'(m));
    write_reg(REG_MISMATCH_SCORE, PARAM_W'(mm));
    write_reg(REG_GAP_OPEN, PARAM_W'(go));
    write_reg(REG_GAP_EXT, PARAM_W'(ge));
  endtask

  // Stop offering items, wait for every expected score, then let a row finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a four-letter alphabet so that matches are common
  function automatic logic [SYM_W-1:0] pick_symbol(int base);
    if ($urandom_range(0, 3) == 0) return SYM_W'($urandom_range(0, 255));
    return SYM_W'(base + $urandom_range(0, 3));
  endfunction

  task automatic load_reference(int n, int base, bit close);
    for (int k = 0; k < n; k++)
      send_item(OP_LOAD, pick_symbol(base), close && (k == n - 1));
  endtask

  task automatic send_query(int n, int base);
    for (int k = 0; k < n; k++)
      send_item(OP_QUERY, pick_symbol(base), k == n - 1);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset register values, empty and open references, field extremes
  task automatic test_basic();
    send_item(OP_QUERY, 8'h00, 1'b1);
    drain_results();
    write_reg(REG_GLOBAL_MODE, 8'd1);
    send_item(OP_QUERY, 8'hFF, 1'b0);
    send_item(OP_QUERY, 8'h7E, 1'b1);
    drain_results();
    write_reg(REG_GLOBAL_MODE, 8'd0);
    send_item(OP_LOAD, 8'h00, 1'b0);
    send_item(OP_LOAD, 8'hFF, 1'b0);
    send_item(OP_LOAD, 8'h41, 1'b0);
    send_item(OP_LOAD, 8'h80, 1'b1);
    send_item(OP_QUERY, 8'hFF, 1'b0);
    send_item(OP_QUERY, 8'h41, 1'b0);
    send_item(OP_QUERY, 8'h80, 1'b1);
    send_item(OP_QUERY, 8'h00, 1'b1);
    // open reference: queries use the symbols stored so far
    send_item(OP_LOAD, 8'h41, 1'b0);
    send_item(OP_QUERY, 8'h41, 1'b1);
    send_item(OP_LOAD, 8'h43, 1'b1);
    send_item(OP_QUERY, 8'h43, 1'b0);
    send_item(OP_QUERY, 8'h41, 1'b1);
  endtask

  // Register extremes in both modes
  task automatic test_extremes();
    int base;
    base = $urandom_range(0, 252);
    drain_results();
    load_reference(6, base, 1'b1);
    drain_results();
    set_config(1'b1, 127, -128, 255, 255);
    send_query(5, base);
    drain_results();
    set_config(1'b0, -128, 127, 0, 0);
    send_query(5, base);
    drain_results();
    set_config(1'b0, 127, -128, 0, 255);
    send_query(5, base);
    drain_results();
    set_config(1'b1, -128, 127, 255, 0);
    send_query(5, base);
  endtask

  // Reference longer than the store, full-width rows, then a fresh reference
  task automatic test_ref_overflow();
    int base;
    base = $urandom_range(0, 252);
    drain_results();
    set_config(1'b0, 2, -1, 2, 1);
    load_reference(REF_DEPTH + 2, base, 1'b1);
    send_query(4, base);
    drain_results();
    write_reg(REG_GLOBAL_MODE, 8'd1);
    send_query(3, base);
    load_reference(2, base, 1'b1);
    send_query(2, base);
  endtask

  // One query running one row past the row limit
  task automatic test_long_query();
    int base;
    base = $urandom_range(0, 252);
    drain_results();
    set_config(1'b1, 3, -2, 1, 1);
    load_reference(2, base, 1'b1);
    send_query(QUERY_DEPTH + 1, base);
  endtask

  // Loads arriving in the middle of a query drop it
  task automatic test_abandon();
    int base;
    base = $urandom_range(0, 252);
    load_reference(5, base, 1'b1);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_LOAD, pick_symbol(base), 1'b0);
    send_item(OP_LOAD, pick_symbol(base), 1'b0);
    send_item(OP_LOAD, pick_symbol(base), 1'b1);
    send_query(3, base);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_LOAD, pick_symbol(base), 1'b1);
    send_query(2, base);
  endtask

  // Register changes between rows of one query
  task automatic test_midquery_config();
    int base;
    base = $urandom_range(0, 252);
    load_reference(4, base, 1'b1);
    drain_results();
    set_config(1'b0, 2, -1, 2, 1);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    drain_results();
    set_config(1'b1, 4, -3, 1, 2);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b1);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    send_item(OP_QUERY, pick_symbol(base), 1'b0);
    drain_results();
    write_reg(REG_GLOBAL_MODE, 8'd0);
    send_query(2, base);
  endtask

  // Long receiver hold-off fills the block; then a full pause of the sender
  task automatic test_pressure();
    int base;
    base = $urandom_range(0, 252);
    drain_results();
    set_config(1'b0, 2, -1, 1, 1);
    load_reference(3, base, 1'b1);
    hold_len = HOLD_CYCLES;
    repeat (40) send_query(1, base);
    drain_results();
    repeat (10) send_query(2, base);
  endtask

  task automatic random_config();
    bit g;
    int m;
    int mm;
    int go;
    int ge;
    g = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        m  = $urandom_range(0, 255) - 128;
        mm = $urandom_range(0, 255) - 128;
        go = $urandom_range(0, 255);
        ge = $urandom_range(0, 255);
      end
      1: begin
        m  = $urandom_range(0, 1) ? 127 : -128;
        mm = $urandom_range(0, 1) ? 127 : -128;
        go = $urandom_range(0, 1) ? 255 : 0;
        ge = $urandom_range(0, 1) ? 255 : 0;
      end
      default: begin
        m  = $urandom_range(1, 8);
        mm = -$urandom_range(0, 6);
        go = $urandom_range(0, 5);
        ge = $urandom_range(0, 3);
      end
    endcase
    set_config(g, m, mm, go, ge);
  endtask

  // Random phases: new settings, a reference, then a few queries
  task automatic test_random(int n_target, bit allow_idle);
    int first;
    int rlen;
    int nq;
    int qlen;
    int base;
    first = n_queries;
    while (n_queries - first < n_target) begin
      drain_results();
      random_config();
      idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      base = $urandom_range(0, 252);
      case ($urandom_range(0, 23))
        0: rlen = 0;
        1: rlen = $urandom_range(REF_DEPTH - 6, REF_DEPTH + 2);
        default: rlen = $urandom_range(1, 16);
      endcase
      if (rlen > 0) load_reference(rlen, base, $urandom_range(0, 7) != 0);
      nq = $urandom_range(1, 4);
      for (int k = 0; k < nq; k++) begin
        qlen = (rlen > 200) ? $urandom_range(1, 3) : $urandom_range(1, 10);
        // broken query: cut off by a reference load
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(OP_QUERY, pick_symbol(base), 1'b0);
          send_item(OP_LOAD, pick_symbol(base), 1'($urandom_range(0, 1)));
        end
        send_query(qlen, base);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GLOBAL_MODE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    op        <= OP_LOAD;
    symbol    <= '0;
    last      <= 1'b0;
    idle_en   = 1'b1;
    hold_len  = 0;
    n_fail    = 0;
    n_queries = 0;
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_basic();
    test_extremes();
    test_ref_overflow();
    test_long_query();
    test_abandon();
    test_midquery_config();
    test_pressure();
    test_random(100, 1'b1);
    test_random(30, 1'b0);

    drain_results();
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
